// ----- rtl/glt_pkg.sv -----
`default_nettype none

package glt_pkg;

	localparam int QueueDepth = 4;

	localparam logic [3:0] KIND_ERROR     = 4'd0;
	localparam logic [3:0] KIND_SYMBOL    = 4'd1;
	localparam logic [3:0] KIND_STRING    = 4'd2;
	localparam logic [3:0] KIND_INTEGER   = 4'd3;
	localparam logic [3:0] KIND_REGEXP    = 4'd4;
	localparam logic [3:0] KIND_OPEN      = 4'd5;
	localparam logic [3:0] KIND_CLOSE     = 4'd6;
	localparam logic [3:0] KIND_STAR      = 4'd7;
	localparam logic [3:0] KIND_PLUS      = 4'd8;
	localparam logic [3:0] KIND_QUESTION  = 4'd9;
	localparam logic [3:0] KIND_EQUALS    = 4'd10;
	localparam logic [3:0] KIND_PIPE      = 4'd11;
	localparam logic [3:0] KIND_SEMICOLON = 4'd12;
	localparam logic [3:0] KIND_COMMA     = 4'd13;
	localparam logic [3:0] KIND_END       = 4'd14;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] text;
		logic       text_valid;
		logic       done;
	} result_t;

	typedef struct packed {
		logic        two;
		result_t     res0;
		result_t     res1;
		logic [15:0] line;
		logic [15:0] column;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

endpackage

`default_nettype wire

// ----- rtl/glt_front.sv -----
`default_nettype none

module glt_front #(
	parameter int POSITION_WIDTH = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      source_byte,
	input  wire logic            end_of_input,
	output glt_pkg::entry_t      push_entry,
	output logic                 push
);
	import glt_pkg::*;

	typedef enum logic [3:0] {
		M_IDLE, M_COMMENT, M_SYM, M_INT, M_RE, M_RE_ESC, M_STR, M_STR_ESC, M_ERR
	} mode_t;

	typedef struct packed {
		logic    emit;
		result_t res;
		mode_t   mode;
		logic    ok;
	} idle_t;

	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_UNDER     = 8'h5F;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_N         = 8'h6E;

	mode_t                     mode_q, mode_d;
	logic [POSITION_WIDTH-1:0] line_q, line_d;
	logic [POSITION_WIDTH-1:0] col_q, col_d;

	function automatic result_t mk(logic [3:0] kind, logic [7:0] text, logic tv, logic done);
		result_t r;
		r.kind       = kind;
		r.text       = text;
		r.text_valid = tv;
		r.done       = done;
		return r;
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic [3:0] punct_kind(logic [7:0] c);
		logic [3:0] k;
		case (c)
			8'h28:   k = KIND_OPEN;
			8'h29:   k = KIND_CLOSE;
			8'h2A:   k = KIND_STAR;
			8'h2B:   k = KIND_PLUS;
			8'h3F:   k = KIND_QUESTION;
			8'h3D:   k = KIND_EQUALS;
			8'h7C:   k = KIND_PIPE;
			8'h3B:   k = KIND_SEMICOLON;
			8'h2C:   k = KIND_COMMA;
			default: k = KIND_ERROR;
		endcase
		return k;
	endfunction

	function automatic idle_t idle_byte(logic [7:0] c);
		idle_t r;
		r.emit = 1'b0;
		r.res  = '0;
		r.mode = M_IDLE;
		r.ok   = 1'b1;
		if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
			r.mode = M_IDLE;
		end else if (c == CH_HASH) begin
			r.mode = M_COMMENT;
		end else if (is_letter(c)) begin
			r.emit = 1'b1;
			r.res  = mk(KIND_SYMBOL, c, 1'b1, 1'b0);
			r.mode = M_SYM;
		end else if (is_digit(c)) begin
			r.emit = 1'b1;
			r.res  = mk(KIND_INTEGER, c, 1'b1, 1'b0);
			r.mode = M_INT;
		end else if (punct_kind(c) != KIND_ERROR) begin
			r.emit = 1'b1;
			r.res  = mk(punct_kind(c), 8'h00, 1'b0, 1'b1);
		end else if (c == CH_SLASH) begin
			r.mode = M_RE;
		end else if (c == CH_QUOTE) begin
			r.mode = M_STR;
		end else begin
			r.emit = 1'b1;
			r.res  = mk(KIND_ERROR, 8'h00, 1'b0, 1'b1);
			r.mode = M_ERR;
			r.ok   = 1'b0;
		end
		return r;
	endfunction

	idle_t       ib;
	logic [1:0]  n;
	result_t     r0, r1;
	logic        counted;
	logic [15:0] line_out, col_out;

	always_comb begin
		ib      = idle_byte(source_byte);
		n       = 2'd0;
		r0      = '0;
		r1      = '0;
		counted = 1'b0;
		mode_d  = mode_q;
		if (end_of_input) begin
			unique case (mode_q)
				M_SYM: begin
					r0 = mk(KIND_SYMBOL, 8'h00, 1'b0, 1'b1);
					n  = 2'd1;
				end
				M_INT: begin
					r0 = mk(KIND_INTEGER, 8'h00, 1'b0, 1'b1);
					n  = 2'd1;
				end
				M_RE, M_RE_ESC, M_STR, M_STR_ESC: begin
					r0 = mk(KIND_ERROR, 8'h00, 1'b0, 1'b1);
					n  = 2'd1;
				end
				default: n = 2'd0;
			endcase
			if (n == 2'd1) begin
				r1 = mk(KIND_END, 8'h00, 1'b0, 1'b1);
				n  = 2'd2;
			end else begin
				r0 = mk(KIND_END, 8'h00, 1'b0, 1'b1);
				n  = 2'd1;
			end
			mode_d = M_IDLE;
		end else begin
			unique case (mode_q)
				M_COMMENT: begin
					counted = 1'b1;
					if (source_byte == CH_LF) begin
						mode_d = M_IDLE;
					end
				end
				M_SYM, M_INT: begin
					if (is_digit(source_byte) ||
					    (mode_q == M_SYM && is_letter(source_byte))) begin
						r0      = mk(mode_q == M_SYM ? KIND_SYMBOL : KIND_INTEGER,
						             source_byte, 1'b1, 1'b0);
						n       = 2'd1;
						counted = 1'b1;
					end else begin
						r0      = mk(mode_q == M_SYM ? KIND_SYMBOL : KIND_INTEGER,
						             8'h00, 1'b0, 1'b1);
						r1      = ib.res;
						n       = ib.emit ? 2'd2 : 2'd1;
						mode_d  = ib.mode;
						counted = ib.ok;
					end
				end
				M_RE: begin
					counted = 1'b1;
					n       = 2'd1;
					if (source_byte == CH_SLASH) begin
						r0     = mk(KIND_REGEXP, 8'h00, 1'b0, 1'b1);
						mode_d = M_IDLE;
					end else begin
						r0 = mk(KIND_REGEXP, source_byte, 1'b1, 1'b0);
						if (source_byte == CH_BACKSLASH) begin
							mode_d = M_RE_ESC;
						end
					end
				end
				M_RE_ESC: begin
					counted = 1'b1;
					n       = 2'd1;
					r0      = mk(KIND_REGEXP, source_byte, 1'b1, 1'b0);
					mode_d  = M_RE;
				end
				M_STR: begin
					counted = 1'b1;
					if (source_byte == CH_QUOTE) begin
						r0     = mk(KIND_STRING, 8'h00, 1'b0, 1'b1);
						n      = 2'd1;
						mode_d = M_IDLE;
					end else if (source_byte == CH_BACKSLASH) begin
						mode_d = M_STR_ESC;
					end else begin
						r0 = mk(KIND_STRING, source_byte, 1'b1, 1'b0);
						n  = 2'd1;
					end
				end
				M_STR_ESC: begin
					n = 2'd1;
					if (source_byte == CH_QUOTE || source_byte == CH_BACKSLASH) begin
						r0      = mk(KIND_STRING, source_byte, 1'b1, 1'b0);
						counted = 1'b1;
						mode_d  = M_STR;
					end else if (source_byte == CH_N) begin
						r0      = mk(KIND_STRING, CH_LF, 1'b1, 1'b0);
						counted = 1'b1;
						mode_d  = M_STR;
					end else begin
						r0     = mk(KIND_ERROR, 8'h00, 1'b0, 1'b1);
						mode_d = M_ERR;
					end
				end
				M_ERR: begin
					mode_d = M_ERR;
				end
				default: begin
					r0      = ib.res;
					n       = ib.emit ? 2'd1 : 2'd0;
					mode_d  = ib.mode;
					counted = ib.ok;
				end
			endcase
		end
	end

	always_comb begin
		line_d = line_q;
		col_d  = col_q;
		if (end_of_input) begin
			line_d = '0;
			col_d  = '0;
		end else if (counted) begin
			if (source_byte == CH_LF) begin
				if (line_q != '1) begin
					line_d = line_q + 1'b1;
				end
				col_d = '0;
			end else if (col_q != '1) begin
				col_d = col_q + 1'b1;
			end
		end
		line_out = end_of_input ? 16'(line_q) : 16'(line_d);
		col_out  = end_of_input ? 16'(col_q) : 16'(col_d);
	end

	assign push              = accept && (n != 2'd0);
	assign push_entry.two    = (n == 2'd2);
	assign push_entry.res0   = r0;
	assign push_entry.res1   = r1;
	assign push_entry.line   = line_out;
	assign push_entry.column = col_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			line_q <= '0;
			col_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			line_q <= line_d;
			col_q  <= col_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/glt_queue.sv -----
`default_nettype none

module glt_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire glt_pkg::entry_t       push_entry,
	input  wire logic                  pop,
	output glt_pkg::entry_t            head,
	output glt_pkg::queue_status_t     status
);
	import glt_pkg::*;

	localparam int PtrW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);

	entry_t          mem_q [QueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] count_q;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CntW'(QueueDepth));
	assign head         = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/glt_back.sv -----
`default_nettype none

module glt_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire glt_pkg::entry_t  head,
	input  wire logic             head_valid,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [3:0]            token_kind,
	output logic [7:0]            text_byte,
	output logic                  text_valid,
	output logic                  token_done,
	output logic [15:0]           line_number,
	output logic [15:0]           column_number,
	output logic                  last_of_run
);
	import glt_pkg::*;

	logic    idx_q;
	result_t cur;
	logic    take;

	assign cur           = idx_q ? head.res1 : head.res0;
	assign out_valid     = head_valid;
	assign token_kind    = cur.kind;
	assign text_byte     = cur.text;
	assign text_valid    = cur.text_valid;
	assign token_done    = cur.done;
	assign line_number   = head.line;
	assign column_number = head.column;
	assign last_of_run   = idx_q || !head.two;
	assign take          = head_valid && !out_stall;
	assign pop           = take && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 1'b0;
		end else if (take) begin
			idx_q <= !last_of_run;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/grammar_token_lexer.sv -----
`default_nettype none

// Channel  Handshake             Payload
// in       in_valid / in_stall   source_byte, end_of_input
// out      out_valid / out_stall token_kind, text_byte, text_valid, token_done,
//                                line_number, column_number, last_of_run
//
// One input transaction is accepted per cycle while the result queue has room.
// Each input yields zero, one or two output transactions; the output side sends
// one per cycle while out_stall is low, so inputs that yield two results are bound by the output port.
// A result is registered in the result queue when its input is accepted and is shown from the queue head.
// Reset clears the lexer mode, both position counters and the queue.
// in_stall is high only while the four-entry result queue is full.

module grammar_token_lexer #(
	parameter int POSITION_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  source_byte,
	input  wire logic        end_of_input,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       token_kind,
	output logic [7:0]       text_byte,
	output logic             text_valid,
	output logic             token_done,
	output logic [15:0]      line_number,
	output logic [15:0]      column_number,
	output logic             last_of_run
);
	import glt_pkg::*;

	entry_t        push_entry, head;
	logic          push, pop, accept;
	queue_status_t status;

	assign in_stall = status.full;
	assign accept   = in_valid && !status.full;

	glt_front #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.source_byte  (source_byte),
		.end_of_input (end_of_input),
		.push_entry   (push_entry),
		.push         (push)
	);

	glt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (status)
	);

	glt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (!status.empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.token_kind    (token_kind),
		.text_byte     (text_byte),
		.text_valid    (text_valid),
		.token_done    (token_done),
		.line_number   (line_number),
		.column_number (column_number),
		.last_of_run   (last_of_run)
	);

endmodule

`default_nettype wire
